// ===== rtl/opmt_pkg.sv =====
// Package for the obstacle point membership test: command codes, sequencer
// states, number formats and the CORDIC arctangent table. No dependencies.
`timescale 1ns / 1ps

package opmt_pkg;

    localparam int MAX_RECTS_DEF   = 64;
    localparam int MAX_CIRCLES_DEF = 64;

    localparam int POS_W    = 24;
    localparam int LEN_W    = 23;
    localparam int ANGLE_W  = 16;
    localparam int MARGIN_W = 20;
    localparam int TRIG_W   = 16;

    localparam int CORDIC_STEPS = 16;
    localparam int CORDIC_W     = 20;
    localparam int STEP_W       = 4;

    localparam logic signed [CORDIC_W-1:0] CORDIC_GAIN = 20'sd39797;
    localparam logic signed [CORDIC_W-1:0] PI_Q16      = 20'sd205887;
    localparam logic signed [CORDIC_W-1:0] HALF_PI_Q16 = 20'sd102944;
    localparam logic signed [CORDIC_W-1:0] ONE_Q14     = 20'sd16384;

    typedef enum logic [1:0] {
        CMD_CLEAR    = 2'd0,
        CMD_ADD_RECT = 2'd1,
        CMD_ADD_CIRC = 2'd2,
        CMD_QUERY    = 2'd3
    } cmd_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_ROT,
        S_SCAN,
        S_DRAIN,
        S_RESP
    } state_t;

    typedef struct packed {
        logic signed [POS_W-1:0]  x;
        logic signed [POS_W-1:0]  y;
        logic [LEN_W-1:0]         w;
        logic [LEN_W-1:0]         h;
        logic signed [TRIG_W-1:0] s;
        logic signed [TRIG_W-1:0] c;
    } rect_entry_t;

    typedef struct packed {
        logic signed [POS_W-1:0] x;
        logic signed [POS_W-1:0] y;
        logic [LEN_W-1:0]        r;
    } circ_entry_t;

    function automatic logic signed [CORDIC_W-1:0] atan_q16(input logic [STEP_W-1:0] i);
        logic signed [CORDIC_W-1:0] v;
        case (i)
            4'd0:    v = 20'sd51472;
            4'd1:    v = 20'sd30386;
            4'd2:    v = 20'sd16055;
            4'd3:    v = 20'sd8150;
            4'd4:    v = 20'sd4091;
            4'd5:    v = 20'sd2047;
            4'd6:    v = 20'sd1024;
            4'd7:    v = 20'sd512;
            4'd8:    v = 20'sd256;
            4'd9:    v = 20'sd128;
            4'd10:   v = 20'sd64;
            4'd11:   v = 20'sd32;
            4'd12:   v = 20'sd16;
            4'd13:   v = 20'sd8;
            4'd14:   v = 20'sd4;
            default: v = 20'sd2;
        endcase
        return v;
    endfunction

endpackage

// ===== rtl/opmt_if.sv =====
// Request and response channel interfaces of the membership test.
// Depends on opmt_pkg.
`timescale 1ns / 1ps

interface opmt_req_if;
    logic                                  valid;
    logic                                  ready;
    logic [1:0]                            cmd;
    logic signed [opmt_pkg::POS_W-1:0]     pos_x;
    logic signed [opmt_pkg::POS_W-1:0]     pos_y;
    logic [opmt_pkg::LEN_W-1:0]            width;
    logic [opmt_pkg::LEN_W-1:0]            height;
    logic signed [opmt_pkg::ANGLE_W-1:0]   angle;
    logic [opmt_pkg::LEN_W-1:0]            radius;

    modport source (output valid, cmd, pos_x, pos_y, width, height, angle, radius,
                    input ready);
    modport sink (input valid, cmd, pos_x, pos_y, width, height, angle, radius,
                  output ready);
endinterface

interface opmt_rsp_if;
    logic valid;
    logic ready;
    logic hit;
    logic dropped;

    modport source (output valid, hit, dropped, input ready);
    modport sink (input valid, hit, dropped, output ready);
endinterface

// ===== rtl/opmt_ram.sv =====
// Generic single-write, single-read synchronous RAM with a registered read.
// No dependencies.
`timescale 1ns / 1ps

module opmt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/opmt_cordic.sv =====
// Iterative 16-step CORDIC giving sine and cosine in signed Q1.14.
// Depends on opmt_pkg.
`timescale 1ns / 1ps

module opmt_cordic (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    input  logic signed [opmt_pkg::ANGLE_W-1:0] angle,
    output logic                                done,
    output logic signed [opmt_pkg::TRIG_W-1:0]  sin_q14,
    output logic signed [opmt_pkg::TRIG_W-1:0]  cos_q14
);
    import opmt_pkg::*;

    logic signed [CORDIC_W-1:0] x_reg, x_next, y_reg, y_next, z_reg, z_next;
    logic [STEP_W-1:0]          step_reg, step_next;
    logic                       busy_reg, busy_next, done_reg, done_next;
    logic                       neg_reg, neg_next;
    logic signed [CORDIC_W-1:0] z0, xs, ys;

    function automatic logic signed [TRIG_W-1:0] to_q14(input logic signed [CORDIC_W-1:0] v,
                                                        input logic neg);
        logic signed [CORDIC_W-1:0] t;
        t = (v + 20'sd2) >>> 2;
        if (t > ONE_Q14)
        begin
            t = ONE_Q14;
        end
        if (t < -ONE_Q14)
        begin
            t = -ONE_Q14;
        end
        if (neg)
        begin
            t = -t;
        end
        return TRIG_W'(t);
    endfunction

    always_comb
    begin
        z0        = CORDIC_W'(angle) <<< 3;
        xs        = x_reg >>> step_reg;
        ys        = y_reg >>> step_reg;
        x_next    = x_reg;
        y_next    = y_reg;
        z_next    = z_reg;
        step_next = step_reg;
        busy_next = busy_reg;
        neg_next  = neg_reg;
        done_next = 1'b0;
        if (start)
        begin
            x_next    = CORDIC_GAIN;
            y_next    = '0;
            step_next = '0;
            busy_next = 1'b1;
            neg_next  = 1'b0;
            z_next    = z0;
            if (z0 > HALF_PI_Q16)
            begin
                z_next   = z0 - PI_Q16;
                neg_next = 1'b1;
            end
            else if (z0 < -HALF_PI_Q16)
            begin
                z_next   = z0 + PI_Q16;
                neg_next = 1'b1;
            end
        end
        else if (busy_reg)
        begin
            if (z_reg >= 0)
            begin
                x_next = x_reg - ys;
                y_next = y_reg + xs;
                z_next = z_reg - atan_q16(step_reg);
            end
            else
            begin
                x_next = x_reg + ys;
                y_next = y_reg - xs;
                z_next = z_reg + atan_q16(step_reg);
            end
            step_next = step_reg + 1'b1;
            if (step_reg == STEP_W'(CORDIC_STEPS - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg   <= x_next;
        y_reg   <= y_next;
        z_reg   <= z_next;
        neg_reg <= neg_next;
    end

    assign done    = done_reg;
    assign sin_q14 = to_q14(y_reg, neg_reg);
    assign cos_q14 = to_q14(x_reg, neg_reg);

endmodule

// ===== rtl/obstacle_point_membership_test_top.sv =====
// Top level of the obstacle point membership test: sequencer, shape RAMs,
// scan pipeline and response register. Depends on opmt_pkg, opmt_if,
// opmt_ram and opmt_cordic.
//
//  Channel   Modport  Moves                                      Handshake
//  req       sink     cmd, pos_x, pos_y, width, height, angle,   valid/ready
//                     radius
//  rsp       source   hit, dropped                               valid/ready
//  cfg       write    safety_margin (cfg_wdata)                  cfg_we only
//
// A request is handled one at a time. A clear returns nothing. A circle
// add with room is written as it is accepted; a rectangle add waits for
// the 16 iterations of the CORDIC. A query reads both RAMs at one entry a
// cycle up to the larger of the two counts, or skips the reads when both
// tables are empty; each read passes three register stages (RAM read,
// offsets, products) and then the compare. Reset clears both counts, the
// margin and all control state; RAM contents are not cleared. A response
// waits in the output register while rsp.ready is low; the block still
// takes the next request meanwhile and holds a further response in S_RESP.
`timescale 1ns / 1ps

module obstacle_point_membership_test_top #(
    parameter int MAX_RECTS   = opmt_pkg::MAX_RECTS_DEF,
    parameter int MAX_CIRCLES = opmt_pkg::MAX_CIRCLES_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    opmt_req_if.sink                         req,
    opmt_rsp_if.source                       rsp,
    input  logic                             cfg_we,
    input  logic [opmt_pkg::MARGIN_W-1:0]    cfg_wdata
);
    import opmt_pkg::*;

    // Address widths of the two RAMs and the shared count/scan width.
    localparam int RAW   = (MAX_RECTS > 1) ? $clog2(MAX_RECTS) : 1;
    localparam int CAW   = (MAX_CIRCLES > 1) ? $clog2(MAX_CIRCLES) : 1;
    localparam int RCW   = $clog2(MAX_RECTS + 1);
    localparam int CCW   = $clog2(MAX_CIRCLES + 1);
    localparam int MAXN  = (MAX_RECTS > MAX_CIRCLES) ? MAX_RECTS : MAX_CIRCLES;
    localparam int CW    = $clog2(MAXN + 1);
    localparam int RECT_W = $bits(rect_entry_t);
    localparam int CIRC_W = $bits(circ_entry_t);

    state_t state_reg, state_next;

    logic [MARGIN_W-1:0] margin_reg;
    logic [RCW-1:0]      rect_count_reg;
    logic [CCW-1:0]      circ_count_reg;
    logic [CW-1:0]       scan_idx_reg;
    logic [CW-1:0]       scan_len;

    // Item held while it is being worked on.
    logic signed [POS_W-1:0] px_reg, py_reg;
    logic [LEN_W-1:0]        w_reg, h_reg;
    logic                    hit_acc_reg, drop_reg;

    // Response register.
    logic rsp_valid_reg, rsp_hit_reg, rsp_drop_reg;

    // Control signals, most of them decoded by the output block of the sequencer.
    logic        accept, rect_full, circ_full;
    logic        do_clear, do_add_circ, do_add_rect_full, do_add_circ_full;
    logic        rect_we, circ_we, issue, rsp_load;
    logic        cordic_start, cordic_done;

    logic signed [TRIG_W-1:0] cordic_sin, cordic_cos;
    rect_entry_t rect_wdata, rect_rdata;
    circ_entry_t circ_wdata, circ_rdata;
    logic [RECT_W-1:0] rect_rdata_raw;
    logic [CIRC_W-1:0] circ_rdata_raw;

    assign rect_full = (rect_count_reg >= RCW'(MAX_RECTS));
    assign circ_full = (circ_count_reg >= CCW'(MAX_CIRCLES));
    assign scan_len  = (CW'(rect_count_reg) > CW'(circ_count_reg)) ?
                       CW'(rect_count_reg) : CW'(circ_count_reg);
    assign accept    = req.valid && req.ready;

    // Scan pipeline valid flags: v1 aligns with RAM read data.
    logic v1_r_reg, v1_c_reg, v2_r_reg, v2_c_reg, v3_r_reg, v3_c_reg;
    logic pipe_busy;
    assign pipe_busy = v1_r_reg || v1_c_reg || v2_r_reg || v2_c_reg ||
                       v3_r_reg || v3_c_reg;

    // Next-state logic.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    case (cmd_t'(req.cmd))
                        CMD_CLEAR:    state_next = S_IDLE;
                        CMD_ADD_RECT: state_next = rect_full ? S_RESP : S_ROT;
                        CMD_ADD_CIRC: state_next = S_RESP;
                        CMD_QUERY:    state_next = (scan_len == '0) ? S_DRAIN : S_SCAN;
                        default:      state_next = S_IDLE;
                    endcase
                end
            end
            S_ROT:
            begin
                if (cordic_done)
                begin
                    state_next = S_RESP;
                end
            end
            S_SCAN:
            begin
                if (scan_idx_reg == scan_len - 1'b1)
                begin
                    state_next = S_DRAIN;
                end
            end
            S_DRAIN:
            begin
                if (!pipe_busy)
                begin
                    state_next = S_RESP;
                end
            end
            S_RESP:
            begin
                if (rsp_load)
                begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // Output logic of the sequencer.
    always_comb
    begin
        req.ready        = (state_reg == S_IDLE);
        do_clear         = accept && (req.cmd == CMD_CLEAR);
        do_add_circ      = accept && (req.cmd == CMD_ADD_CIRC) && !circ_full;
        do_add_circ_full = accept && (req.cmd == CMD_ADD_CIRC) && circ_full;
        do_add_rect_full = accept && (req.cmd == CMD_ADD_RECT) && rect_full;
        cordic_start     = accept && (req.cmd == CMD_ADD_RECT) && !rect_full;
        rect_we          = (state_reg == S_ROT) && cordic_done;
        circ_we          = do_add_circ;
        issue            = (state_reg == S_SCAN);
        rsp_load         = (state_reg == S_RESP) && (!rsp_valid_reg || rsp.ready);
    end

    opmt_cordic u_cordic (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (cordic_start),
        .angle   (req.angle),
        .done    (cordic_done),
        .sin_q14 (cordic_sin),
        .cos_q14 (cordic_cos)
    );

    always_comb
    begin
        rect_wdata.x = px_reg;
        rect_wdata.y = py_reg;
        rect_wdata.w = w_reg;
        rect_wdata.h = h_reg;
        rect_wdata.s = cordic_sin;
        rect_wdata.c = cordic_cos;
        circ_wdata.x = req.pos_x;
        circ_wdata.y = req.pos_y;
        circ_wdata.r = req.radius;
    end

    opmt_ram #(.WIDTH(RECT_W), .DEPTH(MAX_RECTS), .AW(RAW)) u_rect_ram (
        .clk   (clk),
        .we    (rect_we),
        .waddr (rect_count_reg[RAW-1:0]),
        .wdata (rect_wdata),
        .raddr (scan_idx_reg[RAW-1:0]),
        .rdata (rect_rdata_raw)
    );

    opmt_ram #(.WIDTH(CIRC_W), .DEPTH(MAX_CIRCLES), .AW(CAW)) u_circ_ram (
        .clk   (clk),
        .we    (circ_we),
        .waddr (circ_count_reg[CAW-1:0]),
        .wdata (circ_wdata),
        .raddr (scan_idx_reg[CAW-1:0]),
        .rdata (circ_rdata_raw)
    );

    assign rect_rdata = rect_entry_t'(rect_rdata_raw);
    assign circ_rdata = circ_entry_t'(circ_rdata_raw);

    // Stage 2 registers: offsets from the shape centre and the limits.
    logic signed [POS_W:0]    s2_dxr, s2_dyr, s2_dxc, s2_dyc;
    logic signed [TRIG_W-1:0] s2_s, s2_c;
    logic [LEN_W:0]           s2_la, s2_lb, s3_la, s3_lb;
    logic                     s2_zero, s3_zero;
    logic signed [LEN_W:0]    s2_room;

    // Stage 3 registers: products.
    logic signed [POS_W+TRIG_W:0] p_dxc_reg, p_dys_reg, p_dxs_reg, p_dyc_reg;
    logic [2*POS_W+1:0]           p_dx2_reg, p_dy2_reg;
    logic [2*LEN_W-1:0]           p_r2_reg;
    logic                         s3_room_neg;

    // Stage 3 combinational compare.
    logic signed [POS_W+TRIG_W+1:0] a_val, b_val;
    logic signed [POS_W+TRIG_W+2:0] two_a, two_b, lim_a, lim_b;
    logic [2*POS_W+2:0]             d2;
    logic                           rect_hit, circ_hit;

    always_comb
    begin
        a_val = -(POS_W+TRIG_W+2)'(p_dxc_reg) - (POS_W+TRIG_W+2)'(p_dys_reg);
        b_val = (POS_W+TRIG_W+2)'(p_dxs_reg) - (POS_W+TRIG_W+2)'(p_dyc_reg);
        two_a = {a_val, 1'b0};
        two_b = {b_val, 1'b0};
        lim_a = $signed({5'b0, s3_la, 14'b0});
        lim_b = $signed({5'b0, s3_lb, 14'b0});
        rect_hit = v3_r_reg && !s3_zero &&
                   (two_a <= lim_a) && (two_a >= -lim_a) &&
                   (two_b <= lim_b) && (two_b >= -lim_b);
        d2       = (2*POS_W+3)'(p_dx2_reg) + (2*POS_W+3)'(p_dy2_reg);
        circ_hit = v3_c_reg && !s3_room_neg && (d2 <= (2*POS_W+3)'(p_r2_reg));
    end

    always_ff @(posedge clk)
    begin
        // Stage 1 to 2.
        s2_dxr  <= (POS_W+1)'(px_reg) - (POS_W+1)'(rect_rdata.x);
        s2_dyr  <= (POS_W+1)'(py_reg) - (POS_W+1)'(rect_rdata.y);
        s2_s    <= rect_rdata.s;
        s2_c    <= rect_rdata.c;
        s2_zero <= (rect_rdata.w == '0) || (rect_rdata.h == '0);
        s2_la   <= (LEN_W+1)'(rect_rdata.w) + (LEN_W+1)'(margin_reg);
        s2_lb   <= (LEN_W+1)'(rect_rdata.h) + ((LEN_W+1)'(margin_reg) << 1);
        s2_dxc  <= (POS_W+1)'(px_reg) - (POS_W+1)'(circ_rdata.x);
        s2_dyc  <= (POS_W+1)'(py_reg) - (POS_W+1)'(circ_rdata.y);
        s2_room <= $signed((LEN_W+1)'(circ_rdata.r)) - $signed((LEN_W+1)'(margin_reg));
        // Stage 2 to 3.
        p_dxc_reg   <= (POS_W+TRIG_W+1)'(s2_dxr) * (POS_W+TRIG_W+1)'(s2_c);
        p_dys_reg   <= (POS_W+TRIG_W+1)'(s2_dyr) * (POS_W+TRIG_W+1)'(s2_s);
        p_dxs_reg   <= (POS_W+TRIG_W+1)'(s2_dxr) * (POS_W+TRIG_W+1)'(s2_s);
        p_dyc_reg   <= (POS_W+TRIG_W+1)'(s2_dyr) * (POS_W+TRIG_W+1)'(s2_c);
        p_dx2_reg   <= (2*POS_W+2)'((2*POS_W+2)'(s2_dxc) * (2*POS_W+2)'(s2_dxc));
        p_dy2_reg   <= (2*POS_W+2)'((2*POS_W+2)'(s2_dyc) * (2*POS_W+2)'(s2_dyc));
        p_r2_reg    <= (2*LEN_W)'(s2_room[LEN_W-1:0]) * (2*LEN_W)'(s2_room[LEN_W-1:0]);
        s3_room_neg <= s2_room[LEN_W];
        s3_zero     <= s2_zero;
        s3_la       <= s2_la;
        s3_lb       <= s2_lb;
        // Request payload.
        if (accept)
        begin
            px_reg <= req.pos_x;
            py_reg <= req.pos_y;
            w_reg  <= req.width;
            h_reg  <= req.height;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            margin_reg     <= '0;
            rect_count_reg <= '0;
            circ_count_reg <= '0;
            scan_idx_reg   <= '0;
            hit_acc_reg    <= 1'b0;
            drop_reg       <= 1'b0;
            v1_r_reg       <= 1'b0;
            v1_c_reg       <= 1'b0;
            v2_r_reg       <= 1'b0;
            v2_c_reg       <= 1'b0;
            v3_r_reg       <= 1'b0;
            v3_c_reg       <= 1'b0;
            rsp_valid_reg  <= 1'b0;
            rsp_hit_reg    <= 1'b0;
            rsp_drop_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_we)
            begin
                margin_reg <= cfg_wdata;
            end
            if (do_clear)
            begin
                rect_count_reg <= '0;
                circ_count_reg <= '0;
            end
            if (rect_we)
            begin
                rect_count_reg <= rect_count_reg + 1'b1;
            end
            if (circ_we)
            begin
                circ_count_reg <= circ_count_reg + 1'b1;
            end
            if (accept)
            begin
                hit_acc_reg  <= 1'b0;
                drop_reg     <= do_add_rect_full || do_add_circ_full;
                scan_idx_reg <= '0;
            end
            else
            begin
                if (rect_hit || circ_hit)
                begin
                    hit_acc_reg <= 1'b1;
                end
                if (issue)
                begin
                    scan_idx_reg <= scan_idx_reg + 1'b1;
                end
            end
            v1_r_reg <= issue && (scan_idx_reg < CW'(rect_count_reg));
            v1_c_reg <= issue && (scan_idx_reg < CW'(circ_count_reg));
            v2_r_reg <= v1_r_reg;
            v2_c_reg <= v1_c_reg;
            v3_r_reg <= v2_r_reg;
            v3_c_reg <= v2_c_reg;
            if (rsp_load)
            begin
                rsp_valid_reg <= 1'b1;
                rsp_hit_reg   <= hit_acc_reg;
                rsp_drop_reg  <= drop_reg;
            end
            else if (rsp.ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    assign rsp.valid   = rsp_valid_reg;
    assign rsp.hit     = rsp_hit_reg;
    assign rsp.dropped = rsp_drop_reg;

endmodule

// ===== rtl/opmt_checker.sv =====
// Port-level assertions for the membership test, bound to the top level.
// Depends on opmt_pkg and obstacle_point_membership_test_top.
`timescale 1ns / 1ps

module opmt_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       req_valid,
    input logic       req_ready,
    input logic [1:0] req_cmd,
    input logic       rsp_valid,
    input logic       rsp_ready,
    input logic       rsp_hit,
    input logic       rsp_dropped
);
    import opmt_pkg::*;

    // A response that is not taken stays put.
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_hit) && $stable(rsp_dropped))
        else $error("response changed while stalled");

    // A response never reports both a hit and a dropped add.
    a_hit_drop: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> !(rsp_hit && rsp_dropped))
        else $error("hit and dropped both set");

    // Any request other than a clear keeps the block busy, so req_ready drops after it is accepted.
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready && (req_cmd != CMD_CLEAR) |=> !req_ready)
        else $error("request accepted while busy");

endmodule

bind obstacle_point_membership_test_top opmt_checker u_opmt_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .req_valid   (req.valid),
    .req_ready   (req.ready),
    .req_cmd     (req.cmd),
    .rsp_valid   (rsp.valid),
    .rsp_ready   (rsp.ready),
    .rsp_hit     (rsp.hit),
    .rsp_dropped (rsp.dropped)
);

// ===== verif/tb.sv =====
// Self-checking testbench for obstacle_point_membership_test_top.
// Depends on opmt_pkg, opmt_if and the RTL of the block.
`timescale 1ns / 1ps

module tb;
    import opmt_pkg::*;

    // One request as the sender sees it.
    typedef struct {
        cmd_t                 cmd;
        logic signed [23:0]   px;
        logic signed [23:0]   py;
        logic [22:0]          w;
        logic [22:0]          h;
        logic signed [15:0]   ang;
        logic [22:0]          r;
    } shape_req_t;

    // One response: the query verdict and the table-full flag.
    typedef struct {
        logic hit;
        logic dropped;
    } verdict_t;

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic [MARGIN_W-1:0] cfg_wdata;

    opmt_req_if req ();
    opmt_rsp_if rsp ();

    obstacle_point_membership_test_top uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req.sink),
        .rsp       (rsp.source),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    // The clock runs at 50 MHz.
    always
    begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    // Shadow copy of the shape tables and the margin that the predictor keeps.
    longint rect_x [64], rect_y [64], rect_w [64], rect_h [64], rect_s [64], rect_c [64];
    longint circ_x [64], circ_y [64], circ_r [64];
    int     n_rects;
    int     n_circs;
    longint margin;

    verdict_t pending_verdicts[$];
    int       error_count;

    // Idling percentages of both sides and the receiver's long hold-off counter.
    int send_idle_pct;
    int recv_idle_pct;
    int recv_hold;

    // Arctangents of 2^-i in Q.16 radians, one per CORDIC step.
    longint atan_tab [16] = '{51472, 30386, 16055, 8150, 4091, 2047, 1024, 512,
                              256, 128, 64, 32, 16, 8, 4, 2};

    // Rounds a Q.16 CORDIC output to Q1.14 and clamps it to plus or minus one.
    function automatic longint round_q14(input longint v);
        longint q;
        q = (v + 2) >>> 2;
        if (q > 16384)
            q = 16384;
        if (q < -16384)
            q = -16384;
        return q;
    endfunction

    // Sine and cosine of a Q2.13 angle by sixteen rotation steps. Angles
    // outside plus or minus pi/2 are folded by pi and the results negated.
    function automatic void rotation_of(input longint ang, output longint s, output longint c);
        longint z, x, y, xs, ys;
        bit flip;
        z = ang * 8;
        x = 39797;
        y = 0;
        flip = 1'b0;
        if (z > 102944)
        begin
            z = z - 205887;
            flip = 1'b1;
        end
        else if (z < -102944)
        begin
            z = z + 205887;
            flip = 1'b1;
        end
        for (int i = 0; i < 16; i++)
        begin
            xs = x >>> i;
            ys = y >>> i;
            if (z >= 0)
            begin
                x = x - ys;
                y = y + xs;
                z = z - atan_tab[i];
            end
            else
            begin
                x = x + ys;
                y = y - xs;
                z = z + atan_tab[i];
            end
        end
        c = round_q14(x);
        s = round_q14(y);
        if (flip)
        begin
            c = -c;
            s = -s;
        end
    endfunction

    // Point test against one rectangle. The height side carries twice the
    // margin while the width side carries it once; that unevenness is intended.
    function automatic bit point_in_rect(input int k, input longint px, input longint py);
        longint dx, dy, a, b, la, lb;
        if (rect_w[k] == 0 || rect_h[k] == 0)
            return 1'b0;
        dx = px - rect_x[k];
        dy = py - rect_y[k];
        a = -dx * rect_c[k] - dy * rect_s[k];
        b = dx * rect_s[k] - dy * rect_c[k];
        la = (rect_w[k] + margin) * 16384;
        lb = (rect_h[k] + 2 * margin) * 16384;
        if (2 * a > la || 2 * a < -la)
            return 1'b0;
        if (2 * b > lb || 2 * b < -lb)
            return 1'b0;
        return 1'b1;
    endfunction

    // Point test against one circle, shrunk by the margin.
    function automatic bit point_in_circle(input int k, input longint px, input longint py);
        longint dx, dy, room;
        room = circ_r[k] - margin;
        if (room < 0)
            return 1'b0;
        dx = px - circ_x[k];
        dy = py - circ_y[k];
        return (dx * dx + dy * dy) <= room * room;
    endfunction

    // Applies one accepted request to the shadow tables and queues the
    // response it must produce. A clear produces none.
    function automatic void apply_request(input shape_req_t it);
        verdict_t v;
        longint px, py;
        v.hit = 1'b0;
        v.dropped = 1'b0;
        px = it.px;
        py = it.py;
        case (it.cmd)
            CMD_CLEAR:
            begin
                n_rects = 0;
                n_circs = 0;
                return;
            end
            CMD_ADD_RECT:
            begin
                if (n_rects >= 64)
                    v.dropped = 1'b1;
                else
                begin
                    rect_x[n_rects] = px;
                    rect_y[n_rects] = py;
                    rect_w[n_rects] = it.w;
                    rect_h[n_rects] = it.h;
                    rotation_of(it.ang, rect_s[n_rects], rect_c[n_rects]);
                    n_rects++;
                end
            end
            CMD_ADD_CIRC:
            begin
                if (n_circs >= 64)
                    v.dropped = 1'b1;
                else
                begin
                    circ_x[n_circs] = px;
                    circ_y[n_circs] = py;
                    circ_r[n_circs] = it.r;
                    n_circs++;
                end
            end
            default:
            begin
                for (int k = 0; k < n_rects && !v.hit; k++)
                    v.hit = point_in_rect(k, px, py);
                for (int k = 0; k < n_circs && !v.hit; k++)
                    v.hit = point_in_circle(k, px, py);
            end
        endcase
        pending_verdicts.push_back(v);
    endfunction

    task automatic report_mismatch(input string what);
        $display("%0t mismatch: %s", $realtime, what);
        error_count++;
    endtask

    // Offers one request, with random gaps before it, and returns once it is
    // taken. Called and returning at a falling edge.
    task automatic send_request(input shape_req_t it);
        while ($urandom_range(99) < send_idle_pct)
        begin
            req.valid = 1'b0;
            @(negedge clk);
        end
        req.valid  = 1'b1;
        req.cmd    = it.cmd;
        req.pos_x  = it.px;
        req.pos_y  = it.py;
        req.width  = it.w;
        req.height = it.h;
        req.angle  = it.ang;
        req.radius = it.r;
        do
            @(posedge clk);
        while (!req.ready);
        apply_request(it);
        @(negedge clk);
    endtask

    // Drops valid and waits until every response is in, then lets the block
    // finish a possible trailing clear.
    task automatic wait_drained();
        req.valid = 1'b0;
        while (pending_verdicts.size() != 0)
            @(negedge clk);
        repeat (200) @(negedge clk);
    endtask

    task automatic write_margin(input longint value);
        wait_drained();
        cfg_we    = 1'b1;
        cfg_wdata = MARGIN_W'(value);
        @(negedge clk);
        cfg_we = 1'b0;
        margin = value;
    endtask

    function automatic shape_req_t make_req(input cmd_t cmd, input longint px, input longint py,
                                            input longint w, input longint h,
                                            input longint ang, input longint r);
        shape_req_t it;
        it.cmd = cmd;
        it.px  = 24'(px);
        it.py  = 24'(py);
        it.w   = 23'(w);
        it.h   = 23'(h);
        it.ang = 16'(ang);
        it.r   = 23'(r);
        return it;
    endfunction

    // A random coordinate: mostly within about twenty metres, sometimes anywhere.
    function automatic longint rand_pos();
        if ($urandom_range(9) < 7)
            return longint'($urandom_range(163840)) - 81920;
        return longint'($signed(24'($urandom())));
    endfunction

    // A random length: mostly a few metres, sometimes zero or full range.
    function automatic longint rand_len();
        int pick;
        pick = $urandom_range(19);
        if (pick == 0)
            return 0;
        if (pick < 3)
            return $urandom() & 23'h7FFFFF;
        return $urandom_range(20480);
    endfunction

    // Builds one random request. Most queries land near a stored shape so
    // that hits and near misses both occur often.
    function automatic shape_req_t rand_req();
        shape_req_t it;
        int pick, k;
        longint bx, by;
        it = make_req(CMD_QUERY, rand_pos(), rand_pos(), rand_len(), rand_len(),
                      $signed(16'($urandom())), rand_len());
        pick = $urandom_range(99);
        if (pick < 3)
            it.cmd = CMD_CLEAR;
        else if (pick < 25)
            it.cmd = CMD_ADD_RECT;
        else if (pick < 47)
            it.cmd = CMD_ADD_CIRC;
        else if ($urandom_range(9) < 7 && n_rects + n_circs > 0)
        begin
            k = $urandom_range(n_rects + n_circs - 1);
            bx = (k < n_rects) ? rect_x[k] : circ_x[k - n_rects];
            by = (k < n_rects) ? rect_y[k] : circ_y[k - n_rects];
            it.px = 24'(bx + longint'($urandom_range(16384)) - 8192);
            it.py = 24'(by + longint'($urandom_range(16384)) - 8192);
        end
        return it;
    endfunction

    // The receiver: a long hold-off when one is asked for, otherwise
    // random stalls at the current rate.
    initial
    begin
        rsp.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (recv_hold > 0)
            begin
                rsp.ready = 1'b0;
                recv_hold--;
            end
            else
                rsp.ready = ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Compares every response with the oldest expectation.
    always @(posedge clk)
    begin
        verdict_t want;
        if (rst_n && rsp.valid && rsp.ready)
        begin
            if (pending_verdicts.size() == 0)
                report_mismatch("response with no request waiting for it");
            else
            begin
                want = pending_verdicts.pop_front();
                if (rsp.hit !== want.hit)
                    report_mismatch($sformatf("hit %b, expected %b", rsp.hit, want.hit));
                if (rsp.dropped !== want.dropped)
                    report_mismatch($sformatf("dropped %b, expected %b",
                                              rsp.dropped, want.dropped));
            end
        end
    end

    // Extremes of every field, each command, zero-size rectangles, negative
    // circle room and the folding of angles beyond a right angle.
    task automatic test_directed();
        send_request(make_req(CMD_CLEAR, 0, 0, 0, 0, 0, 0));
        send_request(make_req(CMD_QUERY, 0, 0, 0, 0, 0, 0));
        send_request(make_req(CMD_ADD_RECT, 0, 0, 16384, 8192, 0, 0));
        send_request(make_req(CMD_ADD_RECT, 40960, 0, 0, 8192, 0, 0));
        send_request(make_req(CMD_ADD_RECT, -40960, 0, 8192, 0, 0, 0));
        send_request(make_req(CMD_ADD_RECT, 0, 81920, 16384, 4096, 12868, 0));
        send_request(make_req(CMD_ADD_RECT, 0, -81920, 16384, 4096, 32767, 0));
        send_request(make_req(CMD_ADD_RECT, 81920, 81920, 16384, 4096, -32768, 0));
        send_request(make_req(CMD_ADD_CIRC, 8388607, 8388607, 0, 0, 0, 8388607));
        send_request(make_req(CMD_ADD_CIRC, -8388608, -8388608, 0, 0, 0, 4096));
        send_request(make_req(CMD_ADD_RECT, -8388608, 8388607, 8388607, 8388607, 25736, 0));
        send_request(make_req(CMD_QUERY, 8000, 4000, 0, 0, 0, 0));
        send_request(make_req(CMD_QUERY, 8300, 0, 0, 0, 0, 0));
        send_request(make_req(CMD_QUERY, 40960, 0, 0, 0, 0, 0));
        send_request(make_req(CMD_QUERY, 0, 86000, 0, 0, 0, 0));
        send_request(make_req(CMD_QUERY, 2000, -81920, 0, 0, 0, 0));
        send_request(make_req(CMD_QUERY, -8388608, -8388608, 0, 0, 0, 0));
        send_request(make_req(CMD_QUERY, 8388607, -8388608, 0, 0, 0, 0));
        send_request(make_req(CMD_QUERY, -8388608, 8388607, 0, 0, 0, 0));
        write_margin(20'hFFFFF);
        send_request(make_req(CMD_QUERY, -8388608, -8388608, 0, 0, 0, 0));
        send_request(make_req(CMD_QUERY, 40960, 0, 0, 0, 0, 0));
        send_request(make_req(CMD_QUERY, 0, 300000, 0, 0, 0, 0));
        send_request(make_req(CMD_CLEAR, 0, 0, 0, 0, 0, 0));
        send_request(make_req(CMD_QUERY, 0, 0, 0, 0, 0, 0));
    endtask

    // Fills both tables past their depth so the excess adds are dropped.
    task automatic test_table_full();
        write_margin(0);
        send_request(make_req(CMD_CLEAR, 0, 0, 0, 0, 0, 0));
        for (int i = 0; i < 66; i++)
            send_request(make_req(CMD_ADD_RECT, rand_pos(), rand_pos(), rand_len(),
                                  rand_len(), $signed(16'($urandom())), 0));
        for (int i = 0; i < 66; i++)
            send_request(make_req(CMD_ADD_CIRC, rand_pos(), rand_pos(), 0, 0, 0, rand_len()));
        for (int i = 0; i < 6; i++)
            send_request(rand_req());
    endtask

    // The receiver holds off for a long stretch while requests keep coming,
    // then the sender waits until every response has arrived.
    task automatic test_backpressure();
        recv_hold = 600;
        for (int i = 0; i < 12; i++)
            send_request(rand_req());
        wait_drained();
        for (int i = 0; i < 6; i++)
            send_request(rand_req());
    endtask

    // Random traffic under one idling mode and one margin.
    task automatic test_random(input int count, input int s_pct, input int r_pct,
                               input longint m);
        write_margin(m);
        send_idle_pct = s_pct;
        recv_idle_pct = r_pct;
        for (int i = 0; i < count; i++)
            send_request(rand_req());
    endtask

    initial
    begin
        rst_n     = 1'b0;
        cfg_we    = 1'b0;
        cfg_wdata = '0;
        req.valid = 1'b0;
        req.cmd   = CMD_CLEAR;
        req.pos_x = '0;
        req.pos_y = '0;
        req.width = '0;
        req.height = '0;
        req.angle = '0;
        req.radius = '0;
        n_rects = 0;
        n_circs = 0;
        margin = 0;
        error_count = 0;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        recv_hold = 0;
        repeat (2) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        test_directed();
        test_table_full();
        test_backpressure();
        test_random(200, 19, 66, $urandom_range(4096));
        test_random(200, 66, 19, $urandom() & 20'hFFFFF);
        test_random(200, 0, 0, $urandom_range(1024));

        wait_drained();
        if (error_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

    // Guards against a hung handshake.
    initial
    begin
        #20ms;
        $display("FAIL");
        $finish;
    end

endmodule

// ===== files.f =====
rtl/opmt_pkg.sv
rtl/opmt_if.sv
rtl/opmt_ram.sv
rtl/opmt_cordic.sv
rtl/obstacle_point_membership_test_top.sv
rtl/opmt_checker.sv
verif/tb.sv
